// File: src/variable_block_ring_allocator_core_defines.svh
// Assertion macros shared by the ring allocator modules.
`ifndef VARIABLE_BLOCK_RING_ALLOCATOR_CORE_DEFINES_SVH
`define VARIABLE_BLOCK_RING_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The expression must hold at every clock edge outside reset.
`define VBRA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// When the trigger holds, the result must hold in the next cycle.
`define VBRA_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`else

`define VBRA_ASSERT_ALWAYS(lbl, expr, msg)

`define VBRA_ASSERT_NEXT(lbl, trig, expr, msg)

`endif

`endif

// File: src/vbra_pkg.sv
// Shared types and constants for the variable-block ring allocator.
package vbra_pkg;

  // Every block carries a size header of this many bytes ahead of its payload.
  localparam int unsigned HEADER_BYTES = 8;

  // Largest ring the block manages. The offset and fill fields are sized for it.
  localparam int unsigned MAX_CAPACITY = 4096;

  // Width of the fill level field; the capacity register is one bit wider.
  localparam int unsigned FILL_W = 13;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC    = 2'd0;
  localparam logic [1:0] CMD_FREE     = 2'd1;
  localparam logic [1:0] CMD_ROLLBACK = 2'd2;
  localparam logic [1:0] CMD_PROBE    = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_FRAGMENTED = 3'd2;
  localparam logic [2:0] ST_MISMATCH   = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd4;
  localparam logic [2:0] ST_REC_FULL   = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] payload_len;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [11:0] payload_offset;
    logic [12:0] fill_level;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // capture the incoming request
    logic commit;    // execute the held request and load the result register
  } dp_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

// File: src/vbra_ctrl.sv
// Controller state machine: request acceptance, execution and result handshake.
`include "variable_block_ring_allocator_core_defines.svh"

module vbra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vbra_pkg::dp_cmd_t cmd
);

  vbra_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vbra_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = vbra_pkg::S_EXEC;
        end
      end
      vbra_pkg::S_EXEC: begin
        if (out_free) begin
          state_nxt = vbra_pkg::S_IDLE;
        end
      end
      default: state_nxt = vbra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load_req = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      vbra_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      vbra_pkg::S_EXEC: begin
        cmd.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vbra_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted request always moves the controller into execution.
  `VBRA_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_r == vbra_pkg::S_EXEC, "accept did not start execution")
  // A commit always presents a result in the next cycle.
  `VBRA_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_r, "commit without result")

endmodule

// File: src/vbra_dp.sv
// Datapath: ring pointers, fill accounting, size-record memory and result register.
`include "variable_block_ring_allocator_core_defines.svh"

module vbra_dp #(
  parameter int unsigned MAX_BLOCKS   = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vbra_pkg::dp_cmd_t cmd,
  input  vbra_pkg::in_t     in_data,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_wdata,
  output vbra_pkg::out_t    out_data
);

  localparam int unsigned CW = $clog2(vbra_pkg::MAX_CAPACITY + 1);
  localparam int unsigned AW = ((CW > vbra_pkg::FILL_W) ? CW : vbra_pkg::FILL_W) + 1;
  localparam int unsigned SW = $clog2(MAX_BLOCKS);
  localparam int unsigned NW = $clog2(MAX_BLOCKS + 1);

  logic [AW-1:0] cap_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] lbb_r, lbb_nxt;
  logic [AW-1:0] wm_r, wm_nxt;
  logic          wmv_r, wmv_nxt;
  logic [SW-1:0] oldest_r, oldest_nxt;
  logic [SW-1:0] newest_r, newest_nxt;
  logic [NW-1:0] count_r, count_nxt;

  vbra_pkg::in_t  req_r;
  vbra_pkg::out_t out_r, out_nxt;

  logic [11:0] mem [MAX_BLOCKS];
  logic [11:0] rd_data_r;
  logic        mem_we;

  logic [AW-1:0] cap_clamped;

  // Configuration value clamped into the supported capacity range.
  always_comb begin
    cap_clamped = AW'(cfg_wdata);
    if (cap_clamped < AW'(9)) begin
      cap_clamped = AW'(9);
    end else if (cap_clamped > AW'(vbra_pkg::MAX_CAPACITY)) begin
      cap_clamped = AW'(vbra_pkg::MAX_CAPACITY);
    end
  end

  always_comb begin
    logic [AW-1:0] size_w;
    logic [AW-1:0] blk;
    logic [AW-1:0] fill_plus;
    logic [AW-1:0] tail_plus;
    logic [AW-1:0] rec_w;
    logic [AW-1:0] rblock;
    logic [AW-1:0] nh;
    logic [AW-1:0] t;
    logic [AW-1:0] start;
    logic          placed;

    size_w    = AW'(req_r.payload_len);
    blk       = size_w + AW'(vbra_pkg::HEADER_BYTES);
    fill_plus = fill_r + blk;
    tail_plus = tail_r + blk;
    rec_w     = AW'(rd_data_r);
    rblock    = rec_w + AW'(vbra_pkg::HEADER_BYTES);
    nh        = '0;
    t         = '0;
    start     = '0;
    placed    = 1'b1;

    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    lbb_nxt    = lbb_r;
    wm_nxt     = wm_r;
    wmv_nxt    = wmv_r;
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;

    out_nxt.ok             = 1'b1;
    out_nxt.status         = vbra_pkg::ST_OK;
    out_nxt.payload_offset = '0;

    case (req_r.command)
      vbra_pkg::CMD_ALLOC: begin
        if (size_w == '0) begin
          lbb_nxt = '0;
        end else if (fill_plus > cap_r) begin
          out_nxt.ok     = 1'b0;
          out_nxt.status = vbra_pkg::ST_FULL;
        end else if (count_r == NW'(MAX_BLOCKS)) begin
          out_nxt.ok     = 1'b0;
          out_nxt.status = vbra_pkg::ST_REC_FULL;
        end else begin
          if (fill_r == '0) begin
            tail_nxt = blk;
          end else if (wmv_r) begin
            if (tail_plus <= head_r) begin
              start    = tail_r;
              tail_nxt = tail_plus;
            end else begin
              placed = 1'b0;
            end
          end else if (tail_plus <= cap_r) begin
            start    = tail_r;
            tail_nxt = tail_plus;
          end else if (blk <= head_r) begin
            wm_nxt   = tail_r;
            wmv_nxt  = 1'b1;
            tail_nxt = blk;
          end else begin
            placed = 1'b0;
          end
          if (!placed) begin
            tail_nxt       = tail_r;
            wm_nxt         = wm_r;
            wmv_nxt        = wmv_r;
            out_nxt.ok     = 1'b0;
            out_nxt.status = vbra_pkg::ST_FRAGMENTED;
          end else begin
            if (tail_nxt >= cap_r) begin
              tail_nxt = '0;
              wm_nxt   = cap_r;
              wmv_nxt  = 1'b1;
            end
            t                      = start + AW'(vbra_pkg::HEADER_BYTES);
            out_nxt.payload_offset = t[11:0];
            fill_nxt               = fill_plus;
            lbb_nxt                = blk;
            mem_we                 = 1'b1;
            newest_nxt = (newest_r == SW'(MAX_BLOCKS - 1)) ? '0 : newest_r + 1'b1;
            count_nxt              = count_r + 1'b1;
          end
        end
      end
      vbra_pkg::CMD_FREE: begin
        if (size_w != '0 && fill_r != '0 && count_r != '0) begin
          if (rec_w != size_w) begin
            out_nxt.ok     = 1'b0;
            out_nxt.status = vbra_pkg::ST_MISMATCH;
          end else if (fill_r < rblock) begin
            out_nxt.ok     = 1'b0;
            out_nxt.status = vbra_pkg::ST_UNDERFLOW;
          end else begin
            nh = head_r + rblock;
            if (wmv_r && nh >= wm_r) begin
              nh      = '0;
              wmv_nxt = 1'b0;
              wm_nxt  = '0;
            end else if (nh >= cap_r) begin
              nh = '0;
            end
            head_nxt   = nh;
            fill_nxt   = fill_r - rblock;
            oldest_nxt = (oldest_r == SW'(MAX_BLOCKS - 1)) ? '0 : oldest_r + 1'b1;
            count_nxt  = count_r - 1'b1;
            if (count_nxt == '0) begin
              lbb_nxt = '0;
            end
          end
        end
      end
      vbra_pkg::CMD_ROLLBACK: begin
        if (lbb_r != '0) begin
          if (fill_r < lbb_r || count_r == '0) begin
            out_nxt.ok     = 1'b0;
            out_nxt.status = vbra_pkg::ST_UNDERFLOW;
          end else begin
            if (tail_r == '0) begin
              tail_nxt = (cap_r > lbb_r) ? cap_r - lbb_r : '0;
              wmv_nxt  = 1'b0;
              wm_nxt   = '0;
            end else begin
              t = (tail_r >= lbb_r) ? tail_r - lbb_r : '0;
              if (t == '0 && wmv_r && wm_r != cap_r) begin
                t       = wm_r;
                wmv_nxt = 1'b0;
                wm_nxt  = '0;
              end
              tail_nxt = t;
            end
            fill_nxt   = fill_r - lbb_r;
            lbb_nxt    = '0;
            newest_nxt = (newest_r == '0) ? SW'(MAX_BLOCKS - 1) : newest_r - 1'b1;
            count_nxt  = count_r - 1'b1;
          end
        end
      end
      vbra_pkg::CMD_PROBE: begin
        if (size_w != '0 && fill_plus > cap_r) begin
          out_nxt.ok     = 1'b0;
          out_nxt.status = vbra_pkg::ST_FULL;
        end
      end
      default: begin
        out_nxt.ok = 1'b1;
      end
    endcase

    // An empty ring restarts at offset zero with no wrap gap.
    if (fill_nxt == '0) begin
      head_nxt = '0;
      tail_nxt = '0;
      wm_nxt   = '0;
      wmv_nxt  = 1'b0;
    end

    out_nxt.fill_level = fill_nxt[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= AW'(vbra_pkg::MAX_CAPACITY);
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      lbb_r    <= '0;
      wm_r     <= '0;
      wmv_r    <= 1'b0;
      oldest_r <= '0;
      newest_r <= '0;
      count_r  <= '0;
    end else if (cfg_we) begin
      cap_r    <= cap_clamped;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      lbb_r    <= '0;
      wm_r     <= '0;
      wmv_r    <= 1'b0;
      oldest_r <= '0;
      newest_r <= '0;
      count_r  <= '0;
    end else if (cmd.commit) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      lbb_r    <= lbb_nxt;
      wm_r     <= wm_nxt;
      wmv_r    <= wmv_nxt;
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  // Size-record store: one write port at the newest slot, registered read of the oldest.
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      mem[newest_r] <= req_r.payload_len;
    end
    rd_data_r <= mem[oldest_r];
  end

  assign out_data = out_r;

  `VBRA_ASSERT_ALWAYS(a_fill_in_cap, fill_r <= cap_r, "fill level exceeds capacity")
  `VBRA_ASSERT_ALWAYS(a_count_matches_fill, (count_r == '0) == (fill_r == '0), "record count and fill disagree")
  `VBRA_ASSERT_ALWAYS(a_empty_at_origin, fill_r != '0 || (head_r == '0 && tail_r == '0 && !wmv_r), "empty ring not at origin")
  `VBRA_ASSERT_ALWAYS(a_count_bound, count_r <= NW'(MAX_BLOCKS), "record count overflow")

endmodule

// File: src/variable_block_ring_allocator_core.sv
// Top level of the variable-block ring allocator: controller plus datapath.
//
// This block keeps the bookkeeping for a ring of capacity_bytes bytes that holds
// variable-size blocks, each an 8-byte size header followed by its payload. A
// request carries a command (alloc, free oldest, rollback last alloc, probe) and a
// payload size; each request yields exactly one result with ok, a status code, the
// payload offset of a new block and the fill level after the request. Block sizes
// are kept in an on-chip size-record memory of MAX_BLOCKS entries rather than in
// the ring; alloc is refused with the record-full status when it is full. When an
// alloc wraps to offset zero, a wrap mark records where the unused end gap starts
// so that the head can skip it on free. A request is first captured while the
// size-record memory reads the oldest record into its output register, and then
// the command is evaluated and the result register is loaded. A new request is
// taken in the cycle after a result is loaded, so the block takes no new request
// while one is in flight; a result that the sink does not take holds back the
// following execution until the result register frees up. The record memory
// needs no clearing pass after reset, because only written entries are ever read.
// Writing cfg_wdata (clamped to 9..MAX_CAPACITY) empties the ring and must only
// happen while no request is in flight.
module variable_block_ring_allocator_core #(
  parameter int unsigned MAX_BLOCKS   = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vbra_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vbra_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [12:0]    cfg_wdata
);

  // Command bundle from the controller: capture a request, or commit its result.
  vbra_pkg::dp_cmd_t dp_cmd;

  // The controller owns the handshakes on both channels.
  vbra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd)
  );

  // The datapath holds the ring state, the record memory and the result register.
  vbra_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the variable-block ring allocator core.
module tb_top;

  // The size-record store of the block has this many entries.
  localparam int unsigned RECORD_SLOTS = 256;
  localparam int unsigned RING_MAX = 4096;

  // The slowest legal run is far below this many cycles. It covers every request
  // meeting the longest sender gap, the longest receiver stall and the long hold.
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vbra_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vbra_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;

  variable_block_ring_allocator_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predicted allocator state. It is updated in the same time step in which the
  // block accepts a request, so it always reflects every accepted request.
  logic [12:0] ring_capacity;
  logic [11:0] ring_head;
  logic [11:0] ring_tail;
  logic [12:0] ring_fill;
  logic [12:0] undo_bytes;
  logic [12:0] gap_start;
  logic        gap_valid;
  logic [11:0] size_fifo [RECORD_SLOTS];
  logic [7:0]  fifo_rd;
  logic [7:0]  fifo_wr;
  logic [8:0]  fifo_count;

  // Results that the block still owes, oldest first.
  vbra_pkg::out_t pending_outcomes[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Idling controls. A calm side never idles on its own. A long receiver hold is
  // requested by bumping rx_hold_id; the receiver process does the counting.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int unsigned rx_hold_len = 0;
  int unsigned rx_hold_id = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned stall_left = 0;

  // Clears the ring bookkeeping. Both a capacity write and reset do this.
  function automatic void empty_ring();
    ring_head = '0;
    ring_tail = '0;
    ring_fill = '0;
    undo_bytes = '0;
    gap_start = '0;
    gap_valid = 1'b0;
    fifo_rd = '0;
    fifo_wr = '0;
    fifo_count = '0;
  endfunction

  // The register clamps the written value into the legal capacity range.
  function automatic void set_capacity(input logic [12:0] value);
    if (value < 13'd9) begin
      ring_capacity = 13'd9;
    end else if (value > RING_MAX) begin
      ring_capacity = 13'(RING_MAX);
    end else begin
      ring_capacity = value;
    end
    empty_ring();
  endfunction

  // Works out the result of one request and advances the predicted state.
  // Wider locals hold the sums so that nothing wraps before it is compared.
  function automatic vbra_pkg::out_t ring_outcome(input vbra_pkg::in_t req);
    vbra_pkg::out_t res;
    int unsigned size, blk, start, tail, head, fill, cap, nh, rec;
    bit placed;
    size = req.payload_len;
    blk = vbra_pkg::HEADER_BYTES + size;
    tail = ring_tail;
    head = ring_head;
    fill = ring_fill;
    cap = ring_capacity;
    res = '0;
    res.ok = 1'b1;
    res.status = vbra_pkg::ST_OK;
    case (req.command)
      vbra_pkg::CMD_ALLOC: begin
        // Checks run in a fixed order: fill, then record store, then placement.
        if (size == 0) begin
          undo_bytes = '0;
        end else if (fill + blk > cap) begin
          res.ok = 1'b0;
          res.status = vbra_pkg::ST_FULL;
        end else if (fifo_count >= RECORD_SLOTS) begin
          res.ok = 1'b0;
          res.status = vbra_pkg::ST_REC_FULL;
        end else begin
          placed = 1'b1;
          start = 0;
          if (fill == 0) begin
            tail = blk;
          end else if (gap_valid) begin
            // Already wrapped: the only room left is between tail and head.
            if (tail + blk <= head) begin
              start = tail;
              tail = tail + blk;
            end else begin
              placed = 1'b0;
            end
          end else if (tail + blk <= cap) begin
            start = tail;
            tail = tail + blk;
          end else if (blk <= head) begin
            // Wrap to offset zero and remember where the unused end gap begins.
            gap_start = 13'(tail);
            gap_valid = 1'b1;
            tail = blk;
          end else begin
            placed = 1'b0;
          end
          if (!placed) begin
            res.ok = 1'b0;
            res.status = vbra_pkg::ST_FRAGMENTED;
          end else begin
            // A block that ends exactly at the end of the ring leaves the tail at
            // zero, with the wrap mark at the capacity.
            if (tail >= cap) begin
              tail = 0;
              gap_start = 13'(cap);
              gap_valid = 1'b1;
            end
            res.payload_offset = 12'(start + vbra_pkg::HEADER_BYTES);
            fill = fill + blk;
            undo_bytes = 13'(blk);
            size_fifo[fifo_wr] = req.payload_len;
            fifo_wr = fifo_wr + 8'd1;
            fifo_count = fifo_count + 9'd1;
          end
        end
      end
      vbra_pkg::CMD_FREE: begin
        // A zero size, an empty ring or an empty record store is a no-op.
        if (size != 0 && fill != 0 && fifo_count != 0) begin
          rec = size_fifo[fifo_rd];
          if (rec != size) begin
            res.ok = 1'b0;
            res.status = vbra_pkg::ST_MISMATCH;
          end else if (fill < rec + vbra_pkg::HEADER_BYTES) begin
            res.ok = 1'b0;
            res.status = vbra_pkg::ST_UNDERFLOW;
          end else begin
            nh = head + rec + vbra_pkg::HEADER_BYTES;
            if (gap_valid && nh >= gap_start) begin
              // The head skips the unused end gap and the wrap mark is spent.
              nh = 0;
              gap_valid = 1'b0;
              gap_start = '0;
            end else if (nh >= cap) begin
              nh = 0;
            end
            head = nh;
            fill = fill - rec - vbra_pkg::HEADER_BYTES;
            fifo_rd = fifo_rd + 8'd1;
            fifo_count = fifo_count - 9'd1;
            // Freeing the newest block leaves nothing to roll back.
            if (fifo_count == 0) begin
              undo_bytes = '0;
            end
          end
        end
      end
      vbra_pkg::CMD_ROLLBACK: begin
        if (undo_bytes != 0) begin
          if (fill < undo_bytes || fifo_count == 0) begin
            res.ok = 1'b0;
            res.status = vbra_pkg::ST_UNDERFLOW;
          end else begin
            if (tail == 0) begin
              tail = (cap > undo_bytes) ? cap - undo_bytes : 0;
              gap_valid = 1'b0;
              gap_start = '0;
            end else begin
              tail = (tail >= undo_bytes) ? tail - undo_bytes : 0;
              // Undoing the block that wrapped moves the tail back to the gap.
              if (tail == 0 && gap_valid && gap_start != cap) begin
                tail = gap_start;
                gap_valid = 1'b0;
                gap_start = '0;
              end
            end
            fill = fill - undo_bytes;
            undo_bytes = '0;
            fifo_wr = fifo_wr - 8'd1;
            fifo_count = fifo_count - 9'd1;
          end
        end
      end
      default: begin
        if (size != 0 && fill + blk > cap) begin
          res.ok = 1'b0;
          res.status = vbra_pkg::ST_FULL;
        end
      end
    endcase
    // An empty ring always settles back to offset zero.
    if (fill == 0) begin
      head = 0;
      tail = 0;
      gap_start = '0;
      gap_valid = 1'b0;
    end
    ring_head = 12'(head);
    ring_tail = 12'(tail);
    ring_fill = 13'(fill);
    res.fill_level = 13'(fill);
    return res;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offers one request and returns in the time step in which it is accepted.
  // Valid stays high on return, so the caller either sends again at once or
  // calls a task that lowers it before time moves on.
  task automatic send_request(input logic [1:0] cmd, input logic [11:0] size);
    vbra_pkg::in_t req;
    int unsigned gap;
    req.command = cmd;
    req.payload_len = size;
    gap = tx_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outcomes.push_back(ring_outcome(req));
  endtask

  // Lowers valid and waits until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Capacity writes happen only on an idle block, since they empty the ring.
  task automatic write_capacity(input logic [12:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_capacity(value);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    rx_hold_len = cycles;
    rx_hold_id = rx_hold_id + 1;
  endtask

  // One random request. Most frees name the oldest live size so that the ring
  // keeps turning over; the rest are mismatches, noise and odd commands. In the
  // record mode almost every request is a tiny alloc, which drives the record
  // store to its limit long before the ring runs out of bytes.
  task automatic send_random_request(input bit record_mode);
    int unsigned pick, limit;
    logic [11:0] size;
    pick = $urandom_range(0, 99);
    limit = ring_capacity / 5;
    if (limit < 1) limit = 1;
    if (record_mode) begin
      if (pick < 94) begin
        send_request(vbra_pkg::CMD_ALLOC, 12'($urandom_range(1, 7)));
      end else if (pick < 96) begin
        send_request(vbra_pkg::CMD_ALLOC, 12'($urandom_range(2000, 4095)));
      end else if (pick < 98 && fifo_count != 0) begin
        send_request(vbra_pkg::CMD_FREE, size_fifo[fifo_rd]);
      end else begin
        send_request(vbra_pkg::CMD_ROLLBACK, 12'($urandom_range(0, 4095)));
      end
    end else if (pick < 40) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        size = '0;
      end else if (pick == 1) begin
        size = 12'($urandom_range(0, 4095));
      end else if (pick < 10) begin
        size = 12'($urandom_range(1, limit));
      end else begin
        size = 12'($urandom_range(1, limit / 4 + 1));
      end
      send_request(vbra_pkg::CMD_ALLOC, size);
    end else if (pick < 72) begin
      if (fifo_count != 0 && $urandom_range(0, 9) != 0) begin
        size = size_fifo[fifo_rd];
      end else begin
        size = 12'($urandom_range(0, 4095));
      end
      send_request(vbra_pkg::CMD_FREE, size);
    end else if (pick < 84) begin
      send_request(vbra_pkg::CMD_ROLLBACK, 12'($urandom_range(0, 4095)));
    end else if (pick < 94) begin
      send_request(vbra_pkg::CMD_PROBE, 12'($urandom_range(0, limit * 5)));
    end else begin
      send_request(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
    end
  endtask

  // Command extremes, exact fits, mismatches and the no-op cases at full size.
  task automatic test_command_extremes();
    send_request(vbra_pkg::CMD_ALLOC, 12'd0);
    send_request(vbra_pkg::CMD_PROBE, 12'd4095);
    send_request(vbra_pkg::CMD_ALLOC, 12'd4095);
    send_request(vbra_pkg::CMD_ALLOC, 12'd4088);
    send_request(vbra_pkg::CMD_FREE, 12'd100);
    send_request(vbra_pkg::CMD_ROLLBACK, 12'd0);
    send_request(vbra_pkg::CMD_FREE, 12'd7);
    send_request(vbra_pkg::CMD_ALLOC, 12'd5);
    send_request(vbra_pkg::CMD_ALLOC, 12'd0);
    send_request(vbra_pkg::CMD_ROLLBACK, 12'd0);
  endtask

  // A small ring makes wrapping, the end gap and fragmentation easy to reach.
  task automatic test_wrap_and_gap();
    write_capacity(13'd64);
    send_request(vbra_pkg::CMD_ALLOC, 12'd20);
    send_request(vbra_pkg::CMD_ALLOC, 12'd12);
    send_request(vbra_pkg::CMD_FREE, 12'd20);
    send_request(vbra_pkg::CMD_ALLOC, 12'd10);
    send_request(vbra_pkg::CMD_ALLOC, 12'd4);
    send_request(vbra_pkg::CMD_ROLLBACK, 12'd0);
    send_request(vbra_pkg::CMD_ROLLBACK, 12'd0);
    send_request(vbra_pkg::CMD_ALLOC, 12'd4);
    send_request(vbra_pkg::CMD_ALLOC, 12'd12);
    send_request(vbra_pkg::CMD_FREE, 12'd12);
    send_request(vbra_pkg::CMD_FREE, 12'd4);
    send_request(vbra_pkg::CMD_FREE, 12'd12);
    send_request(vbra_pkg::CMD_PROBE, 12'd0);
  endtask

  // Capacity writes below and above the legal range get clamped.
  task automatic test_capacity_limits();
    write_capacity(13'd0);
    send_request(vbra_pkg::CMD_ALLOC, 12'd1);
    send_request(vbra_pkg::CMD_PROBE, 12'd1);
    write_capacity(13'd8191);
    send_request(vbra_pkg::CMD_PROBE, 12'd4088);
    write_capacity(13'd4097);
    send_request(vbra_pkg::CMD_ALLOC, 12'd2730);
    send_request(vbra_pkg::CMD_ALLOC, 12'd1365);
    write_capacity(13'd9);
    send_request(vbra_pkg::CMD_FREE, 12'd2730);
  endtask

  // Random phases, each with its own capacity. One phase opens with a long hold
  // on the result side while requests keep coming, so the block backs up.
  task automatic test_random_traffic();
    logic [12:0] cap_value;
    int unsigned count;
    bit record_mode;
    for (int phase = 0; phase < 6; phase++) begin
      record_mode = 1'b0;
      count = 25;
      case (phase)
        0: cap_value = 13'($urandom_range(9, 128));
        1: begin
          cap_value = 13'(RING_MAX);
          record_mode = 1'b1;
          count = 300;
        end
        2: cap_value = 13'($urandom_range(129, 1024));
        3: cap_value = 13'(RING_MAX);
        4: cap_value = 13'($urandom_range(24, 64));
        default: cap_value = 13'($urandom_range(1025, 4095));
      endcase
      write_capacity(cap_value);
      tx_calm = (phase == 1 || phase == 2);
      rx_calm = (phase == 2);
      if (phase == 1) begin
        hold_receiver(150);
      end
      repeat (count) send_random_request(record_mode);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    set_capacity(13'(RING_MAX));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_command_extremes();
    test_wrap_and_gap();
    test_capacity_limits();
    test_random_traffic();
    drain();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_count = mismatch_count + 1;
    end
  endtask

  // Result side: checks each accepted result against the oldest prediction and
  // drives out_ready with random stalls, calm stretches and the long hold.
  always @(posedge clk) begin
    vbra_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing owed, ok %0d status %0d offset %0d fill %0d",
                 $time, out_data.ok, out_data.status, out_data.payload_offset,
                 out_data.fill_level);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("ok", want.ok, out_data.ok);
        check_field("status", want.status, out_data.status);
        check_field("payload_offset", want.payload_offset, out_data.payload_offset);
        check_field("fill_level", want.fill_level, out_data.fill_level);
      end
    end
    if (rx_hold_id != rx_hold_seen) begin
      rx_hold_seen = rx_hold_id;
      stall_left = rx_hold_len;
    end else if (stall_left == 0 && !rx_calm && $urandom_range(0, 2) == 0) begin
      stall_left = idle_len();
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
